>>> sv/fdc_pkg.sv
package fdc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam int          HEADER_SLACK = 8;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_CMD,
        PH_SEQ_H,
        PH_SEQ_L,
        PH_LEN_H,
        PH_LEN_L,
        PH_DATA,
        PH_CRC_H,
        PH_CRC_L
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  frame_command;
        logic [15:0] frame_sequence;
        logic [8:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [8:0]  payload_index;
    } result_t;

    // crc16-ccitt, msb first, one byte
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/fdc_ifs.sv
interface fdc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_byte;

    modport source (output valid, output start_byte, input ready);
    modport sink (input valid, input start_byte, output ready);
endinterface

interface fdc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  frame_command;
    logic [15:0] frame_sequence;
    logic [8:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;

    modport source (output valid, output result_kind, output frame_command,
                    output frame_sequence, output payload_length, output payload_byte,
                    output payload_index, input ready);
    modport sink (input valid, input result_kind, input frame_command,
                  input frame_sequence, input payload_length, input payload_byte,
                  input payload_index, output ready);
endinterface

>>> sv/frame_deframer_crc16_check.sv
// Frame deframer with CRC16-CCITT check. Takes one received byte per transfer on rx,
// hunts for the start byte (cfg, reset 0xAA), parses command, big-endian sequence and
// length, forwards each payload byte with its index on result, and ends each frame with
// a good or crc-error result. Lengths of RX_BUFFER_BYTES-8 or more drop back to hunting.
// Throughput is one byte per clock cycle: the parser and byte-wide crc update run in
// the cycle the byte is accepted, and the result register is refilled in the same cycle
// it is drained, so rx stalls only while an unread result sits in that register.
module frame_deframer_crc16_check
    import fdc_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = 512
)
(
    input  logic         clk,
    input  logic         rst_n,
    fdc_cfg_if.sink      cfg,
    fdc_byte_if.sink     rx,
    fdc_result_if.source result
);

    logic [7:0] start_value_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;
    logic       in_fire;
    logic       res_valid;
    result_t    res;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !out_valid_reg || result.ready;
    assign in_fire   = rx.valid && rx.ready;

    fdc_parser #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_byte (start_value_reg),
        .in_fire    (in_fire),
        .in_byte    (rx.rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= 8'd170;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                start_value_reg <= cfg.start_byte;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_data_reg.result_kind;
    assign result.frame_command  = out_data_reg.frame_command;
    assign result.frame_sequence = out_data_reg.frame_sequence;
    assign result.payload_length = out_data_reg.payload_length;
    assign result.payload_byte   = out_data_reg.payload_byte;
    assign result.payload_index  = out_data_reg.payload_index;

endmodule

>>> sv/fdc_parser.sv
module fdc_parser
    import fdc_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] start_byte,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam int          CNT_W     = $clog2(RX_BUFFER_BYTES);
    localparam logic [16:0] LEN_LIMIT = 17'(RX_BUFFER_BYTES - HEADER_SLACK);

    phase_t            phase_reg, phase_next;
    logic [7:0]        command_reg, command_next;
    logic [15:0]       sequence_reg, sequence_next;
    logic [15:0]       length_reg, length_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_high_reg, crc_high_next;

    logic [15:0]       crc_upd;
    logic [CNT_W:0]    count_inc;
    logic [16:0]       full_length;
    logic [CNT_W+8:0]  count_ext;

    assign crc_upd     = crc_add_byte(crc_reg, in_byte);
    assign count_inc   = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign full_length = {length_reg[15:8], in_byte} == 16'd0 ? 17'd0
                       : {1'b0, length_reg[15:8], in_byte};
    assign count_ext   = {9'd0, count_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == start_byte)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:   phase_next = PH_SEQ_H;
                PH_SEQ_H: phase_next = PH_SEQ_L;
                PH_SEQ_L: phase_next = PH_LEN_H;
                PH_LEN_H: phase_next = PH_LEN_L;
                PH_LEN_L:
                begin
                    if (full_length == 17'd0)
                    begin
                        phase_next = PH_CRC_H;
                    end
                    else if (full_length >= LEN_LIMIT)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (17'(count_inc) >= {1'b0, length_reg})
                    begin
                        phase_next = PH_CRC_H;
                    end
                end
                PH_CRC_H: phase_next = PH_CRC_L;
                PH_CRC_L: phase_next = PH_HUNT;
                default:  phase_next = PH_HUNT;
            endcase
        end
    end

    // held fields, crc and results
    always_comb
    begin
        command_next  = command_reg;
        sequence_next = sequence_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        res_valid     = 1'b0;
        res.result_kind    = KIND_PAYLOAD;
        res.frame_command  = command_reg;
        res.frame_sequence = sequence_reg;
        res.payload_length = length_reg[8:0];
        res.payload_byte   = 8'd0;
        res.payload_index  = 9'd0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == start_byte)
                    begin
                        crc_next   = CRC_INIT;
                        count_next = '0;
                    end
                end
                PH_CMD:
                begin
                    command_next = in_byte;
                    crc_next     = crc_upd;
                end
                PH_SEQ_H:
                begin
                    sequence_next = {in_byte, 8'd0};
                    crc_next      = crc_upd;
                end
                PH_SEQ_L:
                begin
                    sequence_next = {sequence_reg[15:8], in_byte};
                    crc_next      = crc_upd;
                end
                PH_LEN_H:
                begin
                    length_next = {in_byte, 8'd0};
                    crc_next    = crc_upd;
                end
                PH_LEN_L:
                begin
                    length_next = {length_reg[15:8], in_byte};
                    crc_next    = crc_upd;
                    count_next  = '0;
                end
                PH_DATA:
                begin
                    crc_next          = crc_upd;
                    count_next        = count_inc[CNT_W-1:0];
                    res_valid         = 1'b1;
                    res.payload_byte  = in_byte;
                    res.payload_index = count_ext[8:0];
                end
                PH_CRC_H:
                begin
                    crc_high_next = in_byte;
                end
                PH_CRC_L:
                begin
                    res_valid       = 1'b1;
                    res.result_kind = ({crc_high_reg, in_byte} == crc_reg) ? KIND_GOOD
                                                                          : KIND_CRC_ERR;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            command_reg  <= '0;
            sequence_reg <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            crc_reg      <= CRC_INIT;
            crc_high_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            command_reg  <= command_next;
            sequence_reg <= sequence_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top
    import fdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_BUFFER_BYTES = 512;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_ITEMS     = 105;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fdc_cfg_if    cfg_ch ();
    fdc_byte_if   rx_ch ();
    fdc_result_if res_ch ();

    frame_deframer_crc16_check #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // deframer state as the testbench sees it
    phase_t      pred_phase;
    logic [7:0]  pred_start;
    logic [7:0]  pred_cmd;
    logic [15:0] pred_seq;
    logic [15:0] pred_len;
    logic [19:0] pred_count;
    logic [15:0] pred_crc;
    logic [7:0]  pred_crc_hi;

    result_t expected_results[$];
    int      mismatches = 0;
    int      cyc = 0;
    int      tx_count = 0;
    int      frame_items = 0;
    bit      hold_request = 1'b0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // bit-serial crc16-ccitt, msb first
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] s;
        logic        fb;
        s = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = s[15] ^ d[i];
            s = {s[14:0], 1'b0};
            if (fb)
            begin
                s = s ^ CRC_POLY;
            end
        end
        return s;
    endfunction

    function automatic result_t mk_result(input kind_t k, input logic [7:0] c,
                                          input logic [15:0] sq, input logic [8:0] ln,
                                          input logic [7:0] pb, input logic [8:0] pi);
        result_t r;
        r.result_kind    = k;
        r.frame_command  = c;
        r.frame_sequence = sq;
        r.payload_length = ln;
        r.payload_byte   = pb;
        r.payload_index  = pi;
        return r;
    endfunction

    task automatic deframe_step(input logic [7:0] b, output bit has, output result_t r);
        logic [15:0] got_crc;
        has = 1'b0;
        r = '0;
        case (pred_phase)
            PH_HUNT:
            begin
                if (b == pred_start)
                begin
                    pred_crc = CRC_INIT;
                    pred_count = '0;
                    pred_phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                pred_cmd = b;
                pred_crc = crc_next(pred_crc, b);
                pred_phase = PH_SEQ_H;
            end
            PH_SEQ_H:
            begin
                pred_seq = {b, 8'h00};
                pred_crc = crc_next(pred_crc, b);
                pred_phase = PH_SEQ_L;
            end
            PH_SEQ_L:
            begin
                pred_seq[7:0] = b;
                pred_crc = crc_next(pred_crc, b);
                pred_phase = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                pred_len = {b, 8'h00};
                pred_crc = crc_next(pred_crc, b);
                pred_phase = PH_LEN_L;
            end
            PH_LEN_L:
            begin
                pred_len[7:0] = b;
                pred_crc = crc_next(pred_crc, b);
                pred_count = '0;
                if (pred_len == 16'd0)
                begin
                    pred_phase = PH_CRC_H;
                end
                else if (int'(pred_len) >= RX_BUFFER_BYTES - HEADER_SLACK)
                begin
                    pred_phase = PH_HUNT;
                end
                else
                begin
                    pred_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                pred_crc = crc_next(pred_crc, b);
                r = mk_result(KIND_PAYLOAD, pred_cmd, pred_seq, pred_len[8:0], b,
                              pred_count[8:0]);
                has = 1'b1;
                pred_count = pred_count + 20'd1;
                if (pred_count >= {4'd0, pred_len})
                begin
                    pred_phase = PH_CRC_H;
                end
            end
            PH_CRC_H:
            begin
                pred_crc_hi = b;
                pred_phase = PH_CRC_L;
            end
            PH_CRC_L:
            begin
                got_crc = {pred_crc_hi, b};
                r = mk_result((got_crc == pred_crc) ? KIND_GOOD : KIND_CRC_ERR, pred_cmd,
                              pred_seq, pred_len[8:0], 8'h00, 9'd0);
                has = 1'b1;
                pred_phase = PH_HUNT;
            end
            default:
            begin
                pred_phase = PH_HUNT;
            end
        endcase
    endtask

    function automatic int tx_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        int      gap;
        bit      has;
        result_t r;
        gap = tx_gap(((tx_count / 80) % 5) == 2);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!rx_ch.ready);
        tx_count++;
        deframe_step(b, has, r);
        if (typed)
        begin
            expected_results.push_back(want);
        end
        else if (has)
        begin
            expected_results.push_back(r);
        end
        @(negedge clk);
    endtask

    task automatic send_frame(input int len, input bit corrupt, input int cut);
        logic [7:0]  fb[$];
        logic [15:0] c;
        logic [15:0] seq;
        int          n;
        seq = 16'($urandom);
        fb.push_back(pred_start);
        fb.push_back(8'($urandom));
        fb.push_back(seq[15:8]);
        fb.push_back(seq[7:0]);
        fb.push_back(8'(len >> 8));
        fb.push_back(8'(len));
        if (len < RX_BUFFER_BYTES - HEADER_SLACK)
        begin
            for (int i = 0; i < len; i++)
            begin
                fb.push_back(8'($urandom));
            end
            c = CRC_INIT;
            for (int i = 1; i < fb.size(); i++)
            begin
                c = crc_next(c, fb[i]);
            end
            if (corrupt)
            begin
                c = c ^ 16'($urandom_range(1, 65535));
            end
            fb.push_back(c[15:8]);
            fb.push_back(c[7:0]);
        end
        n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(fb[i], 1'b0, '0);
        end
        frame_items += n;
    endtask

    // result consumer with random backpressure
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 90;
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (((cyc / 150) % 4) != 1 && r < 25)
                begin
                    res_ch.ready <= 1'b0;
                    stall_left = (r < 22) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
                else
                begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = mk_result(kind_t'(res_ch.result_kind), res_ch.frame_command,
                            res_ch.frame_sequence, res_ch.payload_length,
                            res_ch.payload_byte, res_ch.payload_index);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result: kind %0d cmd %h seq %h len %0d byte %h idx %0d",
                             got.result_kind, got.frame_command, got.frame_sequence,
                             got.payload_length, got.payload_byte, got.payload_index);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.result_kind !== want.result_kind ||
                    got.frame_command !== want.frame_command ||
                    got.frame_sequence !== want.frame_sequence ||
                    got.payload_length !== want.payload_length ||
                    got.payload_byte !== want.payload_byte ||
                    got.payload_index !== want.payload_index)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("wrong result at cycle %0d", cyc);
                        $display("  expected kind %0d cmd %h seq %h len %0d byte %h idx %0d",
                                 want.result_kind, want.frame_command, want.frame_sequence,
                                 want.payload_length, want.payload_byte, want.payload_index);
                        $display("  actual   kind %0d cmd %h seq %h len %0d byte %h idx %0d",
                                 got.result_kind, got.frame_command, got.frame_sequence,
                                 got.payload_length, got.payload_byte, got.payload_index);
                    end
                end
            end
        end
    end

    initial
    begin
        wait (cyc >= CYCLE_LIMIT);
        $display("timeout at cycle %0d, %0d results outstanding", cyc,
                 expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        stim_row_t   directed_rows[$];
        logic [15:0] good_crc;
        logic [15:0] bad_crc;
        logic [7:0]  cfg_values[4];
        int          len;
        int          cut;
        int          r;
        bit          corrupt;

        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.start_byte = 8'h00;

        pred_phase = PH_HUNT;
        pred_start = 8'd170;
        pred_cmd = '0;
        pred_seq = '0;
        pred_len = '0;
        pred_count = '0;
        pred_crc = CRC_INIT;
        pred_crc_hi = '0;

        good_crc = crc_next(crc_next(crc_next(crc_next(crc_next(CRC_INIT, 8'hFF), 8'hFF),
                   8'hFF), 8'h00), 8'h00);
        bad_crc = crc_next(crc_next(crc_next(crc_next(crc_next(crc_next(CRC_INIT, 8'h00),
                  8'h00), 8'h00), 8'h00), 8'h01), 8'hAA) ^ 16'h0001;

        // noise while hunting
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h55, 1'b0, '0});
        // zero-length frame, all-ones command and sequence, good crc
        directed_rows.push_back('{8'hAA, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'hFF, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{good_crc[15:8], 1'b0, '0});
        directed_rows.push_back('{good_crc[7:0], 1'b1,
                                  mk_result(KIND_GOOD, 8'hFF, 16'hFFFF, 9'd0, 8'h00, 9'd0)});
        // one-byte payload equal to the start byte, bad crc
        directed_rows.push_back('{8'hAA, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h00, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b0, '0});
        directed_rows.push_back('{8'hAA, 1'b1,
                                  mk_result(KIND_PAYLOAD, 8'h00, 16'h0000, 9'd1, 8'hAA, 9'd0)});
        directed_rows.push_back('{bad_crc[15:8], 1'b0, '0});
        directed_rows.push_back('{bad_crc[7:0], 1'b1,
                                  mk_result(KIND_CRC_ERR, 8'h00, 16'h0000, 9'd1, 8'h00, 9'd0)});
        // smallest oversized length, back to hunting
        directed_rows.push_back('{8'hAA, 1'b0, '0});
        directed_rows.push_back('{8'h5A, 1'b0, '0});
        directed_rows.push_back('{8'h12, 1'b0, '0});
        directed_rows.push_back('{8'h34, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b0, '0});
        directed_rows.push_back('{8'hF8, 1'b0, '0});
        directed_rows.push_back('{8'h01, 1'b0, '0});

        cfg_values[0] = 8'h00;
        cfg_values[1] = 8'hFF;
        cfg_values[2] = 8'($urandom);
        cfg_values[3] = 8'hAA;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
        end
        rx_ch.valid <= 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            while (expected_results.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (4) @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.start_byte <= cfg_values[p];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ch.ready);
            pred_start = cfg_values[p];
            @(negedge clk);
            cfg_ch.valid <= 1'b0;

            // long consumer hold while frames keep coming
            if (p == 1)
            begin
                hold_request = 1'b1;
            end
            frame_items = 0;
            if (p == 2)
            begin
                send_frame(RX_BUFFER_BYTES - HEADER_SLACK - 1, 1'b0, 0);
            end
            while (frame_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 10)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, '0);
                end
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    len = 0;
                end
                else if (r < 85)
                begin
                    len = $urandom_range(1, 12);
                end
                else if (r < 93)
                begin
                    len = $urandom_range(13, 64);
                end
                else if (r < 96)
                begin
                    len = $urandom_range(65, 300);
                end
                else
                begin
                    len = $urandom_range(RX_BUFFER_BYTES - HEADER_SLACK, 65535);
                end
                corrupt = ($urandom_range(0, 99) < 20);
                cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 8) : 0;
                send_frame(len, corrupt, cut);
            end
            rx_ch.valid <= 1'b0;
        end

        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
